// ===== hdl/oebs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oebs_pkg
// Shared constants and types of the OOK envelope bit slicer.
// ----------------------------------------------------------------------------
package oebs_pkg;

    // Samples summed per decided bit; must be a power of two (average is a shift).
    localparam int SAMPLES_PER_BIT = 16;
    localparam int SPB_LOG2        = (SAMPLES_PER_BIT > 1) ? $clog2(SAMPLES_PER_BIT) : 0;
    localparam int CNT_W           = (SAMPLES_PER_BIT > 1) ? $clog2(SAMPLES_PER_BIT) : 1;

    localparam int SAMPLE_W  = 8;
    localparam int MAG_W     = 17;
    localparam int AVG_W     = 16;
    localparam int SUM_W     = AVG_W + SPB_LOG2;
    localparam int MARGIN_W  = 16;
    localparam int PKT_W     = 10;
    localparam int BITCNT_W  = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [PKT_W-1:0] PKT_BYTES_MIN = PKT_W'(1);
    localparam logic [PKT_W-1:0] PKT_BYTES_MAX = PKT_W'(512);
    localparam logic [AVG_W-1:0] LEVEL_MAX     = AVG_W'(32768);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PKT_BYTES = 1'b1;

    // one average per completed bit period
    typedef struct packed {
        logic             valid;
        logic [AVG_W-1:0] avg;
    } t_avg_beat;

endpackage

// ===== hdl/oebs_sample_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oebs_sample_if
// I/Q sample channel: valid/ready handshake with one signed sample pair.
// ----------------------------------------------------------------------------
interface oebs_sample_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] i_sample;
    logic signed [7:0] q_sample;

    modport source (output valid, output i_sample, output q_sample, input ready);
    modport sink   (input valid, input i_sample, input q_sample, output ready);
endinterface

// ===== hdl/oebs_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oebs_result_if
// Decided bit channel: valid/ready handshake with bit, levels and byte.
// ----------------------------------------------------------------------------
interface oebs_result_if;
    logic        valid;
    logic        ready;
    logic        bit_value;
    logic [15:0] power_average;
    logic [15:0] floor_level;
    logic [7:0]  packed_byte;
    logic        byte_ready;
    logic        packet_last;

    modport source (output valid, output bit_value, output power_average,
                    output floor_level, output packed_byte, output byte_ready,
                    output packet_last, input ready);
    modport sink   (input valid, input bit_value, input power_average,
                    input floor_level, input packed_byte, input byte_ready,
                    input packet_last, output ready);
endinterface

// ===== hdl/oebs_power_acc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oebs_power_acc
// Squared magnitude and per-bit power sum; emits the floored average.
// ----------------------------------------------------------------------------
module oebs_power_acc (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [oebs_pkg::SAMPLE_W-1:0] i_i_sample,
    input  logic signed [oebs_pkg::SAMPLE_W-1:0] i_q_sample,
    output oebs_pkg::t_avg_beat               o_avg
);
    import oebs_pkg::*;

    logic                       r_s1_valid;
    logic signed [SAMPLE_W-1:0] r_i;
    logic signed [SAMPLE_W-1:0] r_q;
    logic                       r_s2_valid;
    logic [MAG_W-1:0]           r_mag;
    logic [CNT_W-1:0]           r_cnt;
    logic [SUM_W-1:0]           r_sum;
    t_avg_beat                  r_avg;

    logic signed [2*SAMPLE_W-1:0] w_ii;
    logic signed [2*SAMPLE_W-1:0] w_qq;
    logic [MAG_W-1:0]             n_mag;
    logic [SUM_W-1:0]             n_sum;
    logic                         w_last;

    assign w_ii   = r_i * r_i;
    assign w_qq   = r_q * r_q;
    assign n_mag  = {1'b0, w_ii} + {1'b0, w_qq};
    assign n_sum  = r_sum + SUM_W'(r_mag);
    assign w_last = (r_cnt == CNT_W'(SAMPLES_PER_BIT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_avg.valid <= 1'b0;
            r_cnt <= '0;
            r_sum <= '0;
        end else if (i_en) begin
            r_s1_valid  <= i_valid;
            r_s2_valid  <= r_s1_valid;
            r_avg.valid <= r_s2_valid && w_last;
            r_avg.avg   <= AVG_W'(n_sum >> SPB_LOG2);
            if (r_s2_valid) begin
                if (w_last) begin
                    r_cnt <= '0;
                    r_sum <= '0;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    r_sum <= n_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_i       <= i_i_sample;
            r_q       <= i_q_sample;
            r_mag     <= n_mag;
        end
    end

    assign o_avg = r_avg;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(SAMPLES_PER_BIT - 1))
        else $error("sample counter beyond bit period");

    a_avg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_avg.valid |-> r_avg.avg <= LEVEL_MAX)
        else $error("average power out of range");

    a_period_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_avg.valid |-> (r_cnt == '0) && (r_sum == '0))
        else $error("bit period not restarted after average");

endmodule

// ===== hdl/ook_envelope_bit_slicer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ook_envelope_bit_slicer
// OOK energy detector with adaptive noise floor and MSB-first byte packing.
//
// Samples enter on i_samp (one signed I/Q pair per beat) and one result beat
// leaves on o_res for every SAMPLES_PER_BIT samples. A result carries the
// decided bit, the average power, the updated noise floor and, on every
// eighth bit, the packed byte with byte_ready; packet_last marks the final
// byte of a packet of packet_bytes bytes.
// Throughput: one sample per cycle while the receiver does not stall. A result
// becomes valid once the beat completing its bit period has passed the
// sample, magnitude, average and result registers, loaded in that order.
// Configuration (threshold margin, packet length) is written through
// i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// Reset (synchronous, active low) clears the sum, floor, bit position and
// the pipeline; margin resets to 0 and packet length to 1 byte.
// When the receiver stalls with a result pending, the whole pipeline holds
// and i_samp.ready drops until the pending result is taken.
// ----------------------------------------------------------------------------
module ook_envelope_bit_slicer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    oebs_sample_if.sink                        i_samp,
    oebs_result_if.source                      o_res,
    input  logic                               i_cfg_we,
    input  logic [oebs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [oebs_pkg::CFG_W-1:0]         i_cfg_data
);
    import oebs_pkg::*;

    logic [MARGIN_W-1:0] r_margin;
    logic [PKT_W-1:0]    r_pkt_bytes;
    logic [AVG_W-1:0]    r_floor;
    logic [BITCNT_W-1:0] r_bitcnt;
    logic [7:0]          r_shift;

    logic                r_out_valid;
    logic                r_out_bit;
    logic [AVG_W-1:0]    r_out_avg;
    logic [AVG_W-1:0]    r_out_floor;
    logic [7:0]          r_out_byte;
    logic                r_out_byte_ready;
    logic                r_out_last;

    logic                w_en;
    t_avg_beat           w_avg;

    logic [AVG_W+3:0]    w_floor_acc;
    logic [AVG_W-1:0]    n_floor;
    logic [MARGIN_W:0]   w_thresh;
    logic                w_bit;
    logic [7:0]          w_byte;
    logic                w_byte_ready;
    logic [PKT_W-1:0]    w_pkt_clamp;
    logic [PKT_W+2:0]    w_pkt_bits;
    logic [BITCNT_W:0]   w_next_cnt;
    logic                w_pkt_end;
    logic [BITCNT_W-1:0] n_bitcnt;
    logic [7:0]          n_shift;

    // advance everything unless a result is pending and not taken
    assign w_en         = !r_out_valid || o_res.ready;
    assign i_samp.ready = w_en;

    oebs_power_acc u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_samp.valid),
        .i_i_sample (i_samp.i_sample),
        .i_q_sample (i_samp.q_sample),
        .o_avg      (w_avg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin    <= '0;
            r_pkt_bytes <= PKT_BYTES_MIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MARGIN:    r_margin    <= MARGIN_W'(i_cfg_data);
                CFG_PKT_BYTES: r_pkt_bytes <= PKT_W'(i_cfg_data);
                default:       ;
            endcase
        end
    end

    // floor = (15*floor + avg) / 16
    assign w_floor_acc = {r_floor, 4'b0000} - {4'b0000, r_floor} + {4'b0000, w_avg.avg};
    assign n_floor     = w_floor_acc[AVG_W+3:4];
    assign w_thresh    = {1'b0, n_floor} + {1'b0, r_margin};
    assign w_bit       = ({1'b0, w_avg.avg} > w_thresh);

    assign w_byte       = (r_bitcnt[2:0] == 3'd0) ? {7'b0, w_bit} : {r_shift[6:0], w_bit};
    assign w_byte_ready = (r_bitcnt[2:0] == 3'd7);

    always_comb begin
        priority if (r_pkt_bytes == '0) begin
            w_pkt_clamp = PKT_BYTES_MIN;
        end else if (r_pkt_bytes > PKT_BYTES_MAX) begin
            w_pkt_clamp = PKT_BYTES_MAX;
        end else begin
            w_pkt_clamp = r_pkt_bytes;
        end
    end

    assign w_pkt_bits = {w_pkt_clamp, 3'b000};
    assign w_next_cnt = {1'b0, r_bitcnt} + (BITCNT_W+1)'(1);
    assign w_pkt_end  = (w_next_cnt >= w_pkt_bits);
    assign n_bitcnt   = w_pkt_end ? '0 : w_next_cnt[BITCNT_W-1:0];
    assign n_shift    = w_pkt_end ? 8'd0 : w_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor     <= '0;
            r_bitcnt    <= '0;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_avg.valid;
            if (w_avg.valid) begin
                r_floor  <= n_floor;
                r_bitcnt <= n_bitcnt;
                r_shift  <= n_shift;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_bit        <= w_bit;
            r_out_avg        <= w_avg.avg;
            r_out_floor      <= n_floor;
            r_out_byte       <= w_byte_ready ? w_byte : 8'd0;
            r_out_byte_ready <= w_byte_ready;
            r_out_last       <= w_byte_ready && w_pkt_end;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.bit_value     = r_out_bit;
    assign o_res.power_average = r_out_avg;
    assign o_res.floor_level   = r_out_floor;
    assign o_res.packed_byte   = r_out_byte;
    assign o_res.byte_ready    = r_out_byte_ready;
    assign o_res.packet_last   = r_out_last;

    a_last_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> r_out_byte_ready)
        else $error("packet end flagged without a completed byte");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_byte_ready |-> r_out_byte == 8'd0)
        else $error("packed byte not cleared on partial byte");

    a_floor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_floor <= LEVEL_MAX)
        else $error("noise floor out of range");

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |=> $stable(r_floor) && $stable(r_bitcnt))
        else $error("slicer state moved during output stall");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the OOK envelope bit slicer.
//
// A driver feeds I/Q sample beats from a queue, and a scoreboard model slices
// every accepted beat into bit decisions. A monitor compares each result beat
// field by field with the oldest decision. Phases move through margin and
// packet-length settings, including their extremes. Each phase sets a
// mix of sender gaps and receiver stalls. One phase holds the receiver off
// long enough to back up the pipeline and also lowers the packet length
// while a packet is in progress.
// ----------------------------------------------------------------------------
module tb;
    import oebs_pkg::*;

    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT   = 5000;

    typedef struct {
        logic signed [7:0] i_s;
        logic signed [7:0] q_s;
    } t_iq_pair;

    typedef struct packed {
        logic        bit_value;
        logic [15:0] power_average;
        logic [15:0] floor_level;
        logic [7:0]  packed_byte;
        logic        byte_ready;
        logic        packet_last;
    } t_decision;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    oebs_sample_if samp_ch ();
    oebs_result_if res_ch ();

    ook_envelope_bit_slicer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_samp     (samp_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    t_iq_pair  iq_pending_q[$];
    t_decision decided_q[$];
    int        samples_queued = 0;
    int        send_idle_pct  = 0;
    int        stall_pct      = 0;
    logic      hold_phase     = 1'b0;
    logic      hold_done;
    int        hold_cnt;
    int        fail_count     = 0;
    int        idle_cycles    = 0;

    // slicer model state and register copies
    logic [15:0] margin_reg = 16'd0;
    logic [9:0]  pkt_reg    = 10'd1;
    logic [9:0]  smp_cnt;
    logic [25:0] pwr_sum;
    logic [15:0] floor_lvl;
    logic [11:0] bit_pos;
    logic [7:0]  shift_reg;

    function automatic void slice_sample(input logic signed [7:0] si,
                                         input logic signed [7:0] sq);
        int        ii;
        int        qq;
        int        avg;
        int        lim_bytes;
        int        next_pos;
        t_decision d;
        ii = si;
        qq = sq;
        pwr_sum = pwr_sum + 26'(ii * ii + qq * qq);
        if (int'(smp_cnt) + 1 < SAMPLES_PER_BIT) begin
            smp_cnt = smp_cnt + 10'd1;
            return;
        end
        avg       = int'(pwr_sum) / SAMPLES_PER_BIT;
        floor_lvl = 16'((int'(floor_lvl) * 15 + avg) / 16);
        // threshold is formed at full width, no wrap
        d.bit_value = (avg > int'(floor_lvl) + int'(margin_reg));
        if (bit_pos[2:0] == 3'd0) begin
            shift_reg = {7'd0, d.bit_value};
        end else begin
            shift_reg = {shift_reg[6:0], d.bit_value};
        end
        d.byte_ready    = (bit_pos[2:0] == 3'd7);
        d.packed_byte   = d.byte_ready ? shift_reg : 8'd0;
        d.power_average = 16'(avg);
        d.floor_level   = floor_lvl;
        lim_bytes = (pkt_reg == 10'd0) ? 1 : (int'(pkt_reg) > 512) ? 512 : int'(pkt_reg);
        next_pos  = int'(bit_pos) + 1;
        // end the packet here, even if the length shrank below the position
        if (next_pos >= lim_bytes * 8) begin
            d.packet_last = d.byte_ready;
            next_pos      = 0;
            shift_reg     = 8'd0;
        end else begin
            d.packet_last = 1'b0;
        end
        bit_pos = 12'(next_pos);
        smp_cnt = 10'd0;
        pwr_sum = 26'd0;
        decided_q.push_back(d);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // sample driver, feeds the scoreboard model on every accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            samp_ch.valid <= 1'b0;
            smp_cnt   = 10'd0;
            pwr_sum   = 26'd0;
            floor_lvl = 16'd0;
            bit_pos   = 12'd0;
            shift_reg = 8'd0;
        end else begin
            if (samp_ch.valid && samp_ch.ready) begin
                slice_sample(samp_ch.i_sample, samp_ch.q_sample);
            end
            if (!samp_ch.valid || samp_ch.ready) begin
                if (iq_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    samp_ch.valid    <= 1'b1;
                    samp_ch.i_sample <= iq_pending_q[0].i_s;
                    samp_ch.q_sample <= iq_pending_q[0].q_s;
                    void'(iq_pending_q.pop_front());
                end else begin
                    samp_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_cnt     <= 0;
            hold_done    <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (decided_q.size() == 0) begin
                    $error("result beat with no decided bit pending");
                    fail_count++;
                end else begin
                    check_field("bit_value", decided_q[0].bit_value, res_ch.bit_value);
                    check_field("power_average", decided_q[0].power_average,
                                res_ch.power_average);
                    check_field("floor_level", decided_q[0].floor_level, res_ch.floor_level);
                    check_field("packed_byte", decided_q[0].packed_byte, res_ch.packed_byte);
                    check_field("byte_ready", decided_q[0].byte_ready, res_ch.byte_ready);
                    check_field("packet_last", decided_q[0].packet_last, res_ch.packet_last);
                    void'(decided_q.pop_front());
                end
            end
            if (hold_phase && !hold_done) begin
                res_ch.ready <= 1'b0;
                hold_cnt     <= hold_cnt + 1;
                if (hold_cnt == LONG_HOLD_CYCLES - 1) hold_done <= 1'b1;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((samp_ch.valid && samp_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ook_envelope_bit_slicer test failed");
                $finish;
            end
        end
    end

    task automatic push_pair(input logic signed [7:0] a, input logic signed [7:0] b);
        t_iq_pair p;
        p.i_s = a;
        p.q_s = b;
        iq_pending_q.push_back(p);
        samples_queued++;
    endtask

    function automatic logic signed [7:0] rand_amp(input int lo, input int hi);
        int v;
        v = $urandom_range(hi, lo);
        if ($urandom_range(1) == 1) v = -v;
        if (v > 127) v = -128;
        return 8'(v);
    endfunction

    // bit periods of carrier or quiet, with the odd period of pure noise
    task automatic queue_bits(input int nbits);
        int   pad;
        logic carrier;
        logic noisy;
        pad = (SAMPLES_PER_BIT - samples_queued % SAMPLES_PER_BIT) % SAMPLES_PER_BIT;
        repeat (pad) push_pair(8'($urandom), 8'($urandom));
        repeat (nbits) begin
            carrier = 1'($urandom_range(1));
            noisy   = ($urandom_range(9) == 0);
            repeat (SAMPLES_PER_BIT) begin
                if (noisy) begin
                    push_pair(8'($urandom), 8'($urandom));
                end else if (carrier) begin
                    push_pair(rand_amp(48, 128), rand_amp(48, 128));
                end else begin
                    push_pair(rand_amp(0, 12), rand_amp(0, 12));
                end
            end
        end
    endtask

    task automatic wait_quiet();
        do @(posedge i_clk);
        while (iq_pending_q.size() != 0 || samp_ch.valid || decided_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MARGIN) begin
            margin_reg = val;
        end else if (idx == CFG_PKT_BYTES) begin
            pkt_reg = val[PKT_W-1:0];
        end
    endtask

    task automatic run_phase(input logic [15:0] margin, input logic [15:0] pkt,
                             input int idle_pct, input int stall,
                             input int nbits, input logic long_hold);
        wait_quiet();
        write_reg(CFG_MARGIN, margin);
        write_reg(CFG_PKT_BYTES, pkt);
        send_idle_pct <= idle_pct;
        stall_pct     <= stall;
        if (long_hold) hold_phase <= 1'b1;
        queue_bits(nbits);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_MARGIN;
        i_cfg_data       = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full-scale period gives the largest average, then corner samples
        repeat (SAMPLES_PER_BIT) push_pair(8'sh80, 8'sh80);
        push_pair(8'sd127, 8'sd127);
        push_pair(8'sd127, 8'sh80);
        push_pair(8'sh80, 8'sd127);
        push_pair(8'sd0, 8'sd0);
        push_pair(-8'sd1, -8'sd1);
        push_pair(8'sd1, 8'sd1);
        push_pair(8'sd0, 8'sh80);
        push_pair(8'sh80, 8'sd0);
        push_pair(8'sd0, 8'sd127);

        run_phase(16'd0,    16'd1,    0,  0,  12, 1'b0);
        run_phase(16'd500,  16'd2,    79, 0,  12, 1'b0);
        run_phase(16'hFFFF, 16'd0,    0,  79, 8,  1'b0);
        run_phase(16'd1200, 16'd1023, 27, 27, 14, 1'b0);
        // shrink the packet mid-way and back up the pipeline
        run_phase(16'd3000, 16'd1,    0,  0,  20, 1'b1);
        run_phase(16'd100,  16'hFC03, 27, 27, 10, 1'b0);
        run_phase(16'd250,  16'd512,  0,  79, 10, 1'b0);
        wait_quiet();

        if (fail_count == 0) begin
            $display("ook_envelope_bit_slicer test passed");
        end else begin
            $display("ook_envelope_bit_slicer test failed");
        end
        $finish;
    end

endmodule
